// ===== design/kdmfe_pkg.sv =====
// kdmfe_pkg: shared types and fixed constants of the kiwi drive motor frame encoder
// no dependencies; used by kdmfe_mul and kiwi_drive_motor_frame_encoder_top
`timescale 1ns / 1ps

package kdmfe_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_LIN,
        S_SUM,
        S_MLO,
        S_MHI,
        S_FRM,
        S_ENA,
        S_FLUSH,
        S_RAW
    } t_state;

    // request kinds
    typedef enum logic [1:0] {
        KIND_VEL    = 2'd0,
        KIND_SAFETY = 2'd1,
        KIND_RAW    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] CFG_ROT_GAIN = 2'd0;
    localparam logic [1:0] CFG_RPM_GAIN = 2'd1;
    localparam logic [1:0] CFG_ACCEL    = 2'd2;
    localparam logic [1:0] CFG_LIMIT    = 2'd3;

    // configuration reset values
    localparam logic [15:0] ROT_GAIN_RST = 16'd8192;
    localparam logic [16:0] RPM_GAIN_RST = 17'd20861;
    localparam logic [7:0]  ACCEL_RST    = 8'd220;
    localparam logic [11:0] LIMIT_RST    = 12'd3000;

    // shared multiplier geometry
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int LO_W    = 32;
    localparam int GAIN_W  = 17;

    // cos 30 degrees in Q30
    localparam longint unsigned COS30_Q30 = 64'd929887697;

    // frame bytes and lengths
    localparam logic [7:0] BYTE_SPEED_CMD  = 8'hF6;
    localparam logic [7:0] BYTE_ENABLE_CMD = 8'hF3;
    localparam logic [7:0] BYTE_ENABLE_ON  = 8'h01;
    localparam logic [3:0] LEN_SPEED       = 4'd5;
    localparam logic [3:0] LEN_ENABLE      = 4'd3;
    localparam logic [3:0] LEN_MAX         = 4'd8;

endpackage

// ===== design/kiwi_drive_motor_frame_encoder_top.sv =====
// kiwi_drive_motor_frame_encoder_top: three-wheel omni drive command to motor frames
// depends on kdmfe_pkg and kdmfe_mul
`timescale 1ns / 1ps

// A velocity request (x, y in mm/s, yaw in mrad/s) becomes one F6 speed frame per
// motor, motors 1 to 3 in order, the last marked with last_frame. A safety request
// that turns safety off yields a single flush result with no frame; one that turns
// it back on yields three F3 01 enable frames, the first flagged flush_queue. Raw
// requests pass through as one frame, length held to eight bytes. While safety is
// off velocity and raw requests give nothing. Timing: the block takes one request
// at a time and stalls its input until the last result is in the output register.
// A velocity request works through two set-up products, then five steps per wheel,
// all of it through one shared 33 x 18 multiplier; requests that give no result
// leave it ready at once. While the output is stalled with a result still in it,
// the next result waits. Configuration writes are always ready.

module kiwi_drive_motor_frame_encoder_top #(
    parameter int COEF_FRAC_BITS = 15,
    parameter int MOTOR_COUNT    = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    input  logic signed [15:0] i_yaw_rate,
    input  logic               i_safe_on,
    input  logic [10:0]        i_raw_id,
    input  logic [3:0]         i_raw_len,
    input  logic [63:0]        i_raw_payload,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_frame_valid,
    output logic               o_flush_queue,
    output logic [10:0]        o_frame_id,
    output logic [3:0]         o_frame_len,
    output logic [63:0]        o_frame_payload,
    output logic               o_last_frame,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    localparam int F   = COEF_FRAC_BITS;
    localparam int CXW = F + 17;
    localparam int LW  = F + 18;
    localparam int VW  = F + 34;
    localparam int MW  = F + 33;
    localparam int SW  = F + 19;
    localparam int WW  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int GAIN_WL = kdmfe_pkg::GAIN_W;
    localparam logic [WW-1:0] LAST_WHEEL = WW'(MOTOR_COUNT - 1);
    localparam longint unsigned K_COS30_L =
        (kdmfe_pkg::COS30_Q30 + (64'd1 << (29 - F))) >> (30 - F);
    localparam logic [F-1:0] K_COS30 = F'(K_COS30_L);

    // control and configuration state
    kdmfe_pkg::t_state r_state, n_state;
    logic [WW-1:0]     r_wheel, n_wheel;
    logic              r_safety, n_safety;
    logic [15:0]       r_rot_gain;
    logic [16:0]       r_rpm_gain;
    logic [7:0]        r_accel;
    logic [11:0]       r_limit;

    // latched request
    logic signed [15:0] r_x, r_y, r_yaw;
    logic [10:0]        r_raw_id;
    logic [3:0]         r_raw_len;
    logic [63:0]        r_raw_pl;

    // arithmetic intermediates
    logic signed [CXW-1:0] r_cx;
    logic signed [32:0]    r_yr;
    logic signed [LW-1:0]  r_lin;
    logic [MW-1:0]         r_mag;
    logic                  r_neg;
    logic [GAIN_WL-1:0]    r_acc;

    // wheel linear terms and rim speed from the registered intermediates
    logic signed [LW-1:0]  cxe;
    logic signed [LW-1:0]  y_half;
    logic signed [LW-1:0]  y_one;
    logic signed [VW-1:0]  v;

    // output register
    logic        r_ovalid;
    logic        r_o_fvalid, r_o_flush, r_o_last;
    logic [10:0] r_o_id;
    logic [3:0]  r_o_len;
    logic [63:0] r_o_pl;

    // next output values
    logic        ld_out;
    logic        n_o_fvalid, n_o_flush, n_o_last;
    logic [10:0] n_o_id;
    logic [3:0]  n_o_len;
    logic [63:0] n_o_pl;

    // shared multiplier interface
    logic                                  mul_en;
    logic signed [kdmfe_pkg::MUL_A_W-1:0] mul_a;
    logic signed [kdmfe_pkg::MUL_B_W-1:0] mul_b;
    logic signed [kdmfe_pkg::MUL_P_W-1:0] mul_p;

    logic in_acc, out_free;

    assign o_stall     = (r_state != kdmfe_pkg::S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_ovalid || !i_stall;
    assign o_cfg_ready = 1'b1;

    kdmfe_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kdmfe_pkg::S_IDLE;
            r_wheel  <= '0;
            r_safety <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_wheel  <= n_wheel;
            r_safety <= n_safety;
        end
    end

    // sequencer: next state, multiplier operands and result building
    always_comb begin
        logic [SW-1:0] sum;
        logic [SW-1:0] spd_full;
        logic [11:0]   spd;
        logic          dir;
        logic [7:0]    id8;
        logic [7:0]    b1;
        logic [7:0]    b2;
        logic [7:0]    cs;
        logic [3:0]    len_sat;

        n_state    = r_state;
        n_wheel    = r_wheel;
        n_safety   = r_safety;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        ld_out     = 1'b0;
        n_o_fvalid = 1'b1;
        n_o_flush  = 1'b0;
        n_o_last   = 1'b0;
        n_o_id     = '0;
        n_o_len    = '0;
        n_o_pl     = '0;

        sum      = SW'(unsigned'(mul_p)) + SW'(r_acc);
        spd_full = sum >> F;
        spd      = (spd_full > SW'(r_limit)) ? r_limit : spd_full[11:0];
        dir      = r_neg && (r_rpm_gain != '0);
        id8      = 8'(r_wheel) + 8'd1;
        b1       = {dir, 3'b000, spd[11:8]};
        b2       = spd[7:0];
        cs       = '0;
        len_sat  = (r_raw_len > kdmfe_pkg::LEN_MAX) ? kdmfe_pkg::LEN_MAX : r_raw_len;

        unique case (r_state)
            kdmfe_pkg::S_IDLE: begin
                n_wheel = '0;
                if (in_acc) begin
                    priority case (kdmfe_pkg::t_kind'(i_kind))
                        kdmfe_pkg::KIND_VEL: begin
                            if (r_safety) n_state = kdmfe_pkg::S_MUL_X;
                        end
                        kdmfe_pkg::KIND_SAFETY: begin
                            if (r_safety && !i_safe_on) begin
                                n_safety = 1'b0;
                                n_state  = kdmfe_pkg::S_FLUSH;
                            end else if (!r_safety && i_safe_on) begin
                                n_safety = 1'b1;
                                n_state  = kdmfe_pkg::S_ENA;
                            end
                        end
                        kdmfe_pkg::KIND_RAW: begin
                            if (r_safety) n_state = kdmfe_pkg::S_RAW;
                        end
                        default: ;
                    endcase
                end
            end
            // cos30 times x
            kdmfe_pkg::S_MUL_X: begin
                mul_en  = 1'b1;
                mul_a   = kdmfe_pkg::MUL_A_W'(K_COS30);
                mul_b   = kdmfe_pkg::MUL_B_W'(r_x);
                n_state = kdmfe_pkg::S_MUL_Y;
            end
            // yaw rate times rotation gain
            kdmfe_pkg::S_MUL_Y: begin
                mul_en  = 1'b1;
                mul_a   = kdmfe_pkg::MUL_A_W'(r_yaw);
                mul_b   = kdmfe_pkg::MUL_B_W'({1'b0, r_rot_gain});
                n_state = kdmfe_pkg::S_LIN;
            end
            kdmfe_pkg::S_LIN: n_state = kdmfe_pkg::S_SUM;
            kdmfe_pkg::S_SUM: n_state = kdmfe_pkg::S_MLO;
            // low word of magnitude times rpm gain
            kdmfe_pkg::S_MLO: begin
                mul_en  = 1'b1;
                mul_a   = kdmfe_pkg::MUL_A_W'({1'b0, r_mag[kdmfe_pkg::LO_W-1:0]});
                mul_b   = kdmfe_pkg::MUL_B_W'({1'b0, r_rpm_gain});
                n_state = kdmfe_pkg::S_MHI;
            end
            // high part of magnitude times rpm gain
            kdmfe_pkg::S_MHI: begin
                mul_en  = 1'b1;
                mul_a   = kdmfe_pkg::MUL_A_W'(r_mag[MW-1:kdmfe_pkg::LO_W]);
                mul_b   = kdmfe_pkg::MUL_B_W'({1'b0, r_rpm_gain});
                n_state = kdmfe_pkg::S_FRM;
            end
            // speed frame for the current wheel
            kdmfe_pkg::S_FRM: begin
                cs = 8'(id8 + kdmfe_pkg::BYTE_SPEED_CMD + b1 + b2 + r_accel);
                n_o_id   = 11'(id8);
                n_o_len  = kdmfe_pkg::LEN_SPEED;
                n_o_pl   = {24'd0, cs, r_accel, b2, b1, kdmfe_pkg::BYTE_SPEED_CMD};
                n_o_last = (r_wheel == LAST_WHEEL);
                if (out_free) begin
                    ld_out = 1'b1;
                    if (r_wheel == LAST_WHEEL) begin
                        n_state = kdmfe_pkg::S_IDLE;
                    end else begin
                        n_wheel = r_wheel + 1'b1;
                        n_state = kdmfe_pkg::S_LIN;
                    end
                end
            end
            // enable frames after safety comes back on
            kdmfe_pkg::S_ENA: begin
                cs = 8'(id8 + kdmfe_pkg::BYTE_ENABLE_CMD + kdmfe_pkg::BYTE_ENABLE_ON);
                n_o_id    = 11'(id8);
                n_o_len   = kdmfe_pkg::LEN_ENABLE;
                n_o_pl    = {40'd0, cs, kdmfe_pkg::BYTE_ENABLE_ON,
                             kdmfe_pkg::BYTE_ENABLE_CMD};
                n_o_flush = (r_wheel == '0);
                n_o_last  = (r_wheel == LAST_WHEEL);
                if (out_free) begin
                    ld_out = 1'b1;
                    if (r_wheel == LAST_WHEEL) begin
                        n_state = kdmfe_pkg::S_IDLE;
                    end else begin
                        n_wheel = r_wheel + 1'b1;
                    end
                end
            end
            // flush marker after safety goes off
            kdmfe_pkg::S_FLUSH: begin
                n_o_fvalid = 1'b0;
                n_o_flush  = 1'b1;
                n_o_last   = 1'b1;
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = kdmfe_pkg::S_IDLE;
                end
            end
            // raw pass-through, bytes past the length cleared
            kdmfe_pkg::S_RAW: begin
                n_o_id   = r_raw_id;
                n_o_len  = len_sat;
                n_o_last = 1'b1;
                for (int i = 0; i < 8; i++) begin
                    n_o_pl[8*i +: 8] = (4'(i) < len_sat) ? r_raw_pl[8*i +: 8] : 8'd0;
                end
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = kdmfe_pkg::S_IDLE;
                end
            end
            default: n_state = kdmfe_pkg::S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_gain <= kdmfe_pkg::ROT_GAIN_RST;
            r_rpm_gain <= kdmfe_pkg::RPM_GAIN_RST;
            r_accel    <= kdmfe_pkg::ACCEL_RST;
            r_limit    <= kdmfe_pkg::LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kdmfe_pkg::CFG_ROT_GAIN: r_rot_gain <= i_cfg_data[15:0];
                kdmfe_pkg::CFG_RPM_GAIN: r_rpm_gain <= i_cfg_data;
                kdmfe_pkg::CFG_ACCEL:    r_accel    <= i_cfg_data[7:0];
                kdmfe_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // wheel terms and rim speed
    assign cxe    = LW'(r_cx);
    assign y_half = LW'(r_y) <<< (F - 1);
    assign y_one  = LW'(r_y) <<< F;
    assign v      = (VW'(r_lin) <<< 16) + (VW'(r_yr) <<< F);

    // request latch and arithmetic intermediates
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x       <= i_vel_x;
            r_y       <= i_vel_y;
            r_yaw     <= i_yaw_rate;
            r_raw_id  <= i_raw_id;
            r_raw_len <= i_raw_len;
            r_raw_pl  <= i_raw_payload;
        end

        unique case (r_state)
            kdmfe_pkg::S_MUL_Y: r_cx <= CXW'(mul_p);
            // wheel linear term; yaw product still in the multiplier on wheel one
            kdmfe_pkg::S_LIN: begin
                if (r_wheel == '0) r_yr <= 33'(mul_p);
                unique case (r_wheel)
                    WW'(0):  r_lin <= y_half - cxe;
                    WW'(1):  r_lin <= y_half + cxe;
                    default: r_lin <= -y_one;
                endcase
            end
            // rim speed, split into sign and magnitude
            kdmfe_pkg::S_SUM: begin
                r_neg <= v[VW-1];
                r_mag <= MW'(v[VW-1] ? -v : v);
            end
            kdmfe_pkg::S_MHI: r_acc <= mul_p[kdmfe_pkg::LO_W +: GAIN_WL];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ld_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_o_fvalid <= n_o_fvalid;
            r_o_flush  <= n_o_flush;
            r_o_id     <= n_o_id;
            r_o_len    <= n_o_len;
            r_o_pl     <= n_o_pl;
            r_o_last   <= n_o_last;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_frame_valid   = r_o_fvalid;
    assign o_flush_queue   = r_o_flush;
    assign o_frame_id      = r_o_id;
    assign o_frame_len     = r_o_len;
    assign o_frame_payload = r_o_pl;
    assign o_last_frame    = r_o_last;

endmodule

// ===== design/kdmfe_mul.sv =====
// kdmfe_mul: shared signed multiplier with registered product
// depends on kdmfe_pkg for operand widths
`timescale 1ns / 1ps

module kdmfe_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [kdmfe_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [kdmfe_pkg::MUL_B_W-1:0] i_b,
    output logic signed [kdmfe_pkg::MUL_P_W-1:0] o_p
);

    logic signed [kdmfe_pkg::MUL_P_W-1:0] r_p;

    // product held until the next issued operation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= kdmfe_pkg::MUL_P_W'(i_a) * kdmfe_pkg::MUL_P_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for the kiwi drive motor frame encoder, with its own wheel-speed
// and frame predictor, a request driver, a frame monitor, register writes and a cycle watchdog
// depends on kdmfe_pkg and kiwi_drive_motor_frame_encoder_top
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC           = 15;
    localparam int MOTORS         = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int MAX_REPORTS    = 10;
    // cos 30 degrees rounded into the wheel coefficient format
    localparam longint WHEEL_COS  =
        longint'((kdmfe_pkg::COS30_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));

    typedef struct {
        kdmfe_pkg::t_kind   kind;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw;
        logic               safe_on;
        logic [10:0]        raw_id;
        logic [3:0]         raw_len;
        logic [63:0]        raw_payload;
    } t_cmd;

    typedef struct {
        logic        frame_valid;
        logic        flush;
        logic [10:0] id;
        logic [3:0]  len;
        logic [63:0] payload;
        logic        last;
    } t_frame;

    // dut signals, the bench-driven ones all known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_kind = kdmfe_pkg::KIND_VEL;
    logic signed [15:0] i_vel_x = '0;
    logic signed [15:0] i_vel_y = '0;
    logic signed [15:0] i_yaw_rate = '0;
    logic               i_safe_on = 1'b0;
    logic [10:0]        i_raw_id = '0;
    logic [3:0]         i_raw_len = '0;
    logic [63:0]        i_raw_payload = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_frame_valid;
    logic               o_flush_queue;
    logic [10:0]        o_frame_id;
    logic [3:0]         o_frame_len;
    logic [63:0]        o_frame_payload;
    logic               o_last_frame;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = kdmfe_pkg::CFG_ROT_GAIN;
    logic [16:0]        i_cfg_data = '0;

    // bench state
    t_cmd        cmd_queue[$];
    t_frame      pending_frames[$];
    t_cmd        cur_cmd;
    logic [15:0] rot_gain_q = kdmfe_pkg::ROT_GAIN_RST;
    logic [16:0] rpm_gain_q = kdmfe_pkg::RPM_GAIN_RST;
    logic [7:0]  accel_q = kdmfe_pkg::ACCEL_RST;
    logic [11:0] limit_q = kdmfe_pkg::LIMIT_RST;
    logic        safety_q = 1'b1;
    bit          idle_en = 1'b1;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned quiet_cycles = 0;

    kiwi_drive_motor_frame_encoder_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_vel_x         (i_vel_x),
        .i_vel_y         (i_vel_y),
        .i_yaw_rate      (i_yaw_rate),
        .i_safe_on       (i_safe_on),
        .i_raw_id        (i_raw_id),
        .i_raw_len       (i_raw_len),
        .i_raw_payload   (i_raw_payload),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_frame_valid   (o_frame_valid),
        .o_flush_queue   (o_flush_queue),
        .o_frame_id      (o_frame_id),
        .o_frame_len     (o_frame_len),
        .o_frame_payload (o_frame_payload),
        .o_last_frame    (o_last_frame),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // byte-sum checksum over the first n payload bytes plus the identifier
    function automatic logic [7:0] frame_sum(input logic [10:0] id, input logic [63:0] payload,
                                             input int n);
        logic [7:0] s;
        s = id[7:0];
        for (int i = 0; i < n; i++) s += payload[8*i +: 8];
        return s;
    endfunction

    // speed frame for one wheel: rim speed, rpm scaling, truncation and saturation
    function automatic t_frame wheel_frame(input int wheel, input t_cmd c);
        longint       cx;
        longint       cy;
        longint       rim;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [11:0]  rpm;
        logic         dir;
        t_frame       f;
        cx = (wheel == 0) ? -WHEEL_COS : (wheel == 1) ? WHEEL_COS : 64'sd0;
        cy = (wheel == 2) ? -(longint'(1) << FRAC) : (longint'(1) << (FRAC - 1));
        rim = (cx * longint'(c.vel_x) + cy * longint'(c.vel_y)) * 65536
            + longint'(c.yaw) * longint'(rot_gain_q) * (longint'(1) << FRAC);
        mag = (rim < 0) ? 64'(-rim) : 64'(rim);
        prod = ({64'd0, mag} * {111'd0, rpm_gain_q}) >> (FRAC + 32);
        rpm = (prod > {116'd0, limit_q}) ? limit_q : prod[11:0];
        dir = (rim < 0) && (rpm_gain_q != 0);
        f.frame_valid = 1'b1;
        f.flush = 1'b0;
        f.id = 11'(wheel + 1);
        f.len = kdmfe_pkg::LEN_SPEED;
        f.payload = {32'd0, accel_q, rpm[7:0], dir, 3'b000, rpm[11:8],
                     kdmfe_pkg::BYTE_SPEED_CMD};
        f.payload[39:32] = frame_sum(f.id, f.payload, 4);
        f.last = (wheel == MOTORS - 1);
        return f;
    endfunction

    // work out the frames that one accepted request causes and track the safety bit
    task automatic encode_frames(input t_cmd c);
        t_frame      f;
        logic [3:0]  len;
        case (c.kind)
            kdmfe_pkg::KIND_VEL: begin
                if (safety_q) begin
                    for (int w = 0; w < MOTORS; w++) pending_frames.push_back(wheel_frame(w, c));
                end
            end
            kdmfe_pkg::KIND_SAFETY: begin
                if (safety_q && !c.safe_on) begin
                    // falling edge: flush only, no frame
                    safety_q = 1'b0;
                    f.frame_valid = 1'b0;
                    f.flush = 1'b1;
                    f.id = '0;
                    f.len = '0;
                    f.payload = '0;
                    f.last = 1'b1;
                    pending_frames.push_back(f);
                end else if (!safety_q && c.safe_on) begin
                    // rising edge: enable every motor, flushing first
                    safety_q = 1'b1;
                    for (int w = 0; w < MOTORS; w++) begin
                        f.frame_valid = 1'b1;
                        f.flush = (w == 0);
                        f.id = 11'(w + 1);
                        f.len = kdmfe_pkg::LEN_ENABLE;
                        f.payload = {48'd0, kdmfe_pkg::BYTE_ENABLE_ON,
                                     kdmfe_pkg::BYTE_ENABLE_CMD};
                        f.payload[23:16] = frame_sum(f.id, f.payload, 2);
                        f.last = (w == MOTORS - 1);
                        pending_frames.push_back(f);
                    end
                end
            end
            kdmfe_pkg::KIND_RAW: begin
                if (safety_q) begin
                    len = (c.raw_len > kdmfe_pkg::LEN_MAX) ? kdmfe_pkg::LEN_MAX : c.raw_len;
                    f.frame_valid = 1'b1;
                    f.flush = 1'b0;
                    f.id = c.raw_id;
                    f.len = len;
                    f.payload = (len < kdmfe_pkg::LEN_MAX) ?
                        c.raw_payload & ((64'd1 << (8 * len)) - 64'd1) : c.raw_payload;
                    f.last = 1'b1;
                    pending_frames.push_back(f);
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (mismatch_cnt < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) note_mismatch(what, want, got);
    endtask

    // request driver: presents queued requests, with random gaps between them
    always @(posedge i_clk) begin : request_driver
        t_cmd nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) encode_frames(cur_cmd);
            if (!i_valid || !o_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    if (idle_en && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 16) - 1;
                        i_valid <= 1'b0;
                    end else begin
                        nxt = cmd_queue.pop_front();
                        cur_cmd = nxt;
                        i_valid <= 1'b1;
                        i_kind <= nxt.kind;
                        i_vel_x <= nxt.vel_x;
                        i_vel_y <= nxt.vel_y;
                        i_yaw_rate <= nxt.yaw;
                        i_safe_on <= nxt.safe_on;
                        i_raw_id <= nxt.raw_id;
                        i_raw_len <= nxt.raw_len;
                        i_raw_payload <= nxt.raw_payload;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // frame monitor: compares each accepted frame with the oldest prediction
    always @(posedge i_clk) begin : frame_monitor
        t_frame want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_frames.size() == 0) begin
                    note_mismatch("unexpected frame, payload", '0, o_frame_payload);
                end else begin
                    want = pending_frames.pop_front();
                    check_field("frame_valid", want.frame_valid, o_frame_valid);
                    check_field("flush_queue", want.flush, o_flush_queue);
                    check_field("frame_id", want.id, o_frame_id);
                    check_field("frame_len", want.len, o_frame_len);
                    check_field("frame_payload", want.payload, o_frame_payload);
                    check_field("last_frame", want.last, o_last_frame);
                end
            end
            // stall bursts
            if (recv_gap != 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 16) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input kdmfe_pkg::t_kind kind, input int x, input int y,
                                      input int yaw, input logic safe, input int id,
                                      input int len, input logic [63:0] payload);
        t_cmd c;
        c.kind = kind;
        c.vel_x = 16'(x);
        c.vel_y = 16'(y);
        c.yaw = 16'(yaw);
        c.safe_on = safe;
        c.raw_id = 11'(id);
        c.raw_len = 4'(len);
        c.raw_payload = payload;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd        c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        c.kind = (pick < 55) ? kdmfe_pkg::KIND_VEL : (pick < 72) ? kdmfe_pkg::KIND_SAFETY :
                 (pick < 96) ? kdmfe_pkg::KIND_RAW : kdmfe_pkg::KIND_NONE;
        if ($urandom_range(0, 1)) begin
            c.vel_x = 16'($urandom);
            c.vel_y = 16'($urandom);
            c.yaw = 16'($urandom);
        end else begin
            // moderate speeds from -4000 to 4000
            c.vel_x = 16'(int'($urandom_range(0, 8000)) - 4000);
            c.vel_y = 16'(int'($urandom_range(0, 8000)) - 4000);
            c.yaw = 16'(int'($urandom_range(0, 8000)) - 4000);
        end
        c.safe_on = ($urandom_range(0, 9) < 6);
        c.raw_id = 11'($urandom);
        c.raw_len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) :
                                                 4'($urandom_range(0, 8));
        c.raw_payload = {$urandom, $urandom};
        return c;
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) cmd_queue.push_back(random_cmd());
    endtask

    // sender holds off until every predicted frame has arrived and the block is quiet
    task automatic drain();
        while (cmd_queue.size() != 0 || i_valid || pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            kdmfe_pkg::CFG_ROT_GAIN: rot_gain_q = data[15:0];
            kdmfe_pkg::CFG_RPM_GAIN: rpm_gain_q = data;
            kdmfe_pkg::CFG_ACCEL:    accel_q = data[7:0];
            kdmfe_pkg::CFG_LIMIT:    limit_q = data[11:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input int rot, input int rpm, input int accel, input int lim);
        write_reg(kdmfe_pkg::CFG_ROT_GAIN, 17'(rot));
        write_reg(kdmfe_pkg::CFG_RPM_GAIN, 17'(rpm));
        write_reg(kdmfe_pkg::CFG_ACCEL, 17'(accel));
        write_reg(kdmfe_pkg::CFG_LIMIT, 17'(lim));
    endtask

    // stimulus sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every kind, safety edges, raw length saturation
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 0, 0, 0, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 32767, 0, 0, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, -32768, 0, 0, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 0, 32767, 0, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 0, -32768, 0, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 0, 0, 32767, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 0, 0, -32768, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 1000, -500, 200, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, -1, 1, 0, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_RAW, 0, 0, 0, 1, 0, 0, '1));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_RAW, 0, 0, 0, 1, 2047, 8,
                                     64'h5AA5_F00F_1234_C3E1));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_RAW, 0, 0, 0, 1, 1365, 15,
                                     64'hA55A_0FF0_EDCB_3C1E));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_RAW, 0, 0, 0, 1, 682, 3, '1));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_NONE, 123, 456, 789, 1, 5, 2, '1));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_SAFETY, 0, 0, 0, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_SAFETY, 0, 0, 0, 0, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 2000, 2000, 2000, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_RAW, 0, 0, 0, 1, 7, 4, '1));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_SAFETY, 0, 0, 0, 0, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_SAFETY, 0, 0, 0, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, 32767, 32767, 32767, 1, 0, 0, '0));
        cmd_queue.push_back(make_cmd(kdmfe_pkg::KIND_VEL, -32768, -32768, -32768, 1, 0, 0,
                                     '0));
        drain();

        // largest gains and limits
        write_all(65535, 131071, 255, 4095);
        queue_random(110);
        drain();

        // all registers at zero
        write_all(0, 0, 0, 0);
        queue_random(60);
        drain();

        // random settings
        write_all($urandom_range(0, 65535), $urandom_range(0, 131071),
                  $urandom_range(0, 255), $urandom_range(0, 4095));
        queue_random(110);
        drain();

        // back to reset values, flat out with no idling
        idle_en = 1'b0;
        write_all(kdmfe_pkg::ROT_GAIN_RST, kdmfe_pkg::RPM_GAIN_RST, kdmfe_pkg::ACCEL_RST,
                  kdmfe_pkg::LIMIT_RST);
        queue_random(150);
        drain();

        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
